// ===== rtl/mfs_pkg.sv =====
// Shared types and constants for the maximum-frequency stack.
`timescale 1ns / 1ps

package mfs_pkg;

    localparam int MFS_DEPTH = 1024;
    localparam int VALUE_W   = 30;
    localparam int STATUS_W  = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

endpackage

// ===== rtl/max_frequency_stack_top.sv =====
// Maximum-frequency stack: push values, pop the most frequent, topmost on a tie.
// A pop shifts the entries above the removed one down by one place through the single RAM.
// Refused operations skip the scan and go straight to the result; the next transfer in
// is taken once the result is registered.
// Reset (synchronous, active low) empties the stack; stored entries need no clearing.
`timescale 1ns / 1ps

module max_frequency_stack_top
    import mfs_pkg::*;
#(
    parameter int DEPTH = MFS_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_popped_value,
    output logic [STATUS_W-1:0] m_status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = VALUE_W + CNT_W;

    state_t state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   high_reg, high_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pidx_reg, pidx_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   match_reg, match_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] popped_reg, popped_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_popped_value_reg, m_popped_value_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] rd_value;
    logic [CNT_W-1:0]   rd_rank;
    logic [CNT_W-1:0]   new_rank;
    logic [CNT_W-1:0]   shift_dst;
    logic               more;

    mfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value  = ram_rdata[WORD_W-1:CNT_W];
    assign rd_rank   = ram_rdata[CNT_W-1:0];
    assign new_rank  = match_reg + CNT_W'(1);
    assign shift_dst = pidx_reg - CNT_W'(1);
    assign more      = (idx_reg < fill_reg);
    assign ram_raddr = idx_reg[ADDR_W-1:0];

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_value_reg;
    assign m_status       = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            high_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            high_reg    <= high_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg           <= kind_next;
        value_reg          <= value_next;
        idx_reg            <= idx_next;
        pidx_reg           <= pidx_next;
        match_reg          <= match_next;
        pos_reg            <= pos_next;
        popped_reg         <= popped_next;
        status_reg         <= status_next;
        m_popped_value_reg <= m_popped_value_next;
        m_status_reg       <= m_status_next;
    end

    always_comb begin
        state_next          = state_reg;
        kind_next           = kind_reg;
        value_next          = value_reg;
        fill_next           = fill_reg;
        high_next           = high_reg;
        idx_next            = idx_reg;
        pidx_next           = pidx_reg;
        pend_next           = 1'b0;
        match_next          = match_reg;
        pos_next            = pos_reg;
        popped_next         = popped_reg;
        status_next         = status_reg;
        m_valid_next        = m_valid_reg;
        m_popped_value_next = m_popped_value_reg;
        m_status_next       = m_status_reg;
        ram_we              = 1'b0;
        ram_waddr           = fill_reg[ADDR_W-1:0];
        ram_wdata           = {value_reg, new_rank};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    value_next  = s_value;
                    idx_next    = '0;
                    match_next  = '0;
                    popped_next = '0;
                    status_next = STATUS_OK;
                    if (s_kind == KIND_PUSH && fill_reg == CNT_W'(DEPTH)) begin
                        status_next = STATUS_FULL;
                        state_next  = ST_RESULT;
                    end else if (s_kind == KIND_POP && fill_reg == '0) begin
                        status_next = STATUS_EMPTY;
                        state_next  = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Reads are issued one per cycle; the data of index pidx arrives in the cycle after its read.
                if (more) begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pidx_next = idx_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (kind_reg == KIND_PUSH) begin
                        if (rd_value == value_reg) begin
                            match_next = match_reg + CNT_W'(1);
                        end
                    end else if (rd_rank == high_reg) begin
                        match_next  = match_reg + CNT_W'(1);
                        pos_next    = pidx_reg;
                        popped_next = rd_value;
                    end
                end
                if (!more && !pend_reg) begin
                    if (kind_reg == KIND_PUSH) begin
                        ram_we     = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                        if (new_rank > high_reg) begin
                            high_next = new_rank;
                        end
                        state_next = ST_RESULT;
                    end else begin
                        // Ranks of one value are always 1..count, so the highest count
                        // drops by one when its last holder leaves.
                        if (match_reg == CNT_W'(1)) begin
                            high_next = high_reg - CNT_W'(1);
                        end
                        idx_next   = pos_reg + CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (more) begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pidx_next = idx_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (!more && !pend_reg) begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_popped_value_next = popped_reg;
                    m_status_next       = status_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mfs_checker.sv =====
// Port-level assertions for the maximum-frequency stack, bound to the top level.
`timescale 1ns / 1ps

module mfs_checker
    import mfs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_kind,
    input logic [VALUE_W-1:0]  s_value,
    input logic                m_valid,
    input logic                m_ready,
    input logic [VALUE_W-1:0]  m_popped_value,
    input logic [STATUS_W-1:0] m_status
);

    // A result waiting for the sink must hold still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_popped_value) && $stable(m_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_FULL ||
                     m_status == STATUS_EMPTY))
        else $error("undefined status code");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_popped_value == '0)
        else $error("refused operation returned a value");

    // Every transfer in leaves the stack busy, so ready drops after it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again right after a transfer in");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind max_frequency_stack_top mfs_checker u_mfs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_kind         (s_kind),
    .s_value        (s_value),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_popped_value (m_popped_value),
    .m_status       (m_status)
);

// ===== tb/sv/mfs_stack_checker.sv =====
// Checker for the maximum-frequency stack: predicts every reply and compares it.
`timescale 1ns / 1ps

module mfs_stack_checker
    import mfs_pkg::*;
#(
    parameter int DEPTH = MFS_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_kind,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [VALUE_W-1:0]  m_popped_value,
    input  logic [STATUS_W-1:0] m_status,
    output int                  mismatches,
    output int                  pending,
    output int                  pushes_done,
    output int                  pops_done,
    output int                  refusals,
    output int                  peak_fill,
    output int                  peak_rank
);

    typedef struct packed {
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
    } stack_reply_t;

    // Shadow copy of the stack contents, kept in push order.
    logic [VALUE_W-1:0] shadow_values [DEPTH];
    int                 shadow_ranks  [DEPTH];
    // Indexed by rank directly, so entry 0 stays unused.
    int                 rank_counts   [DEPTH+1];
    int                 shadow_fill = 0;
    int                 shadow_top_rank = 0;

    stack_reply_t replies_due [$];
    stack_reply_t want;
    stack_reply_t got;
    int           fail_tally = 0;
    int           push_tally = 0;
    int           pop_tally = 0;
    int           refuse_tally = 0;
    int           fill_high = 0;
    int           rank_high = 0;

    task automatic clear_shadow();
        for (int r = 0; r <= DEPTH; r++) begin
            rank_counts[r] = 0;
        end
        shadow_fill     = 0;
        shadow_top_rank = 0;
        replies_due.delete();
    endtask

    task automatic predict_stack_op(input logic kind, input logic [VALUE_W-1:0] value,
                                    output stack_reply_t reply);
        int match_count;
        int new_rank;
        int pos;
        int i;

        reply.popped = '0;
        reply.status = STATUS_OK;
        if (kind == KIND_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                reply.status = STATUS_FULL;
            end else begin
                match_count = 0;
                for (i = 0; i < shadow_fill; i++) begin
                    if (shadow_values[i] == value) match_count++;
                end
                new_rank = match_count + 1;
                shadow_values[shadow_fill] = value;
                shadow_ranks[shadow_fill]  = new_rank;
                shadow_fill++;
                rank_counts[new_rank]++;
                if (new_rank > shadow_top_rank) shadow_top_rank = new_rank;
            end
        end else if (shadow_fill == 0) begin
            reply.status = STATUS_EMPTY;
        end else begin
            // The victim is the topmost entry whose rank equals the highest count.
            pos = -1;
            for (i = shadow_fill - 1; i >= 0 && pos < 0; i--) begin
                if (shadow_ranks[i] == shadow_top_rank) pos = i;
            end
            if (pos < 0) pos = shadow_fill - 1;
            reply.popped = shadow_values[pos];
            rank_counts[shadow_ranks[pos]]--;
            for (i = pos; i < shadow_fill - 1; i++) begin
                shadow_values[i] = shadow_values[i+1];
                shadow_ranks[i]  = shadow_ranks[i+1];
            end
            shadow_fill--;
            while (shadow_top_rank > 0 && rank_counts[shadow_top_rank] == 0) begin
                shadow_top_rank--;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_shadow();
        end else begin
            // Handle the input transfer first so a same-edge reply still finds its entry.
            if (s_valid && s_ready) begin
                predict_stack_op(s_kind, s_value, want);
                replies_due.push_back(want);
                if (want.status != STATUS_OK) refuse_tally++;
                else if (s_kind == KIND_PUSH) push_tally++;
                else pop_tally++;
                if (shadow_fill > fill_high) fill_high = shadow_fill;
                if (shadow_top_rank > rank_high) rank_high = shadow_top_rank;
            end
            if (m_valid === 1'b1 && m_ready) begin
                got.popped = m_popped_value;
                got.status = m_status;
                if (replies_due.size() == 0) begin
                    $display("%0t ns: reply with none expected, expected nothing, got %h/%0d",
                             $time, got.popped, got.status);
                    fail_tally++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.popped !== want.popped) begin
                        $display("%0t ns: popped_value mismatch, expected %h, got %h",
                                 $time, want.popped, got.popped);
                        fail_tally++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t ns: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fail_tally++;
                    end
                end
            end
        end
        mismatches  <= fail_tally;
        pending     <= replies_due.size();
        pushes_done <= push_tally;
        pops_done   <= pop_tally;
        refusals    <= refuse_tally;
        peak_fill   <= fill_high;
        peak_rank   <= rank_high;
    end

endmodule

// ===== tb/sv/tb_max_frequency_stack_top.sv =====
// Testbench top for the maximum-frequency stack: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_max_frequency_stack_top;
    import mfs_pkg::*;

    localparam int STACK_DEPTH  = MFS_DEPTH;
    localparam int RANDOM_ITEMS = 540;
    // A pop on a full stack takes about two passes over the RAM; this is many times that.
    localparam int IDLE_LIMIT   = 20000;
    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [VALUE_W-1:0]  s_value;
    logic                m_valid;
    logic                m_ready;
    logic [VALUE_W-1:0]  m_popped_value;
    logic [STATUS_W-1:0] m_status;

    int mismatch_total;
    int replies_pending;
    int pushes_done;
    int pops_done;
    int refusals;
    int peak_fill;
    int peak_rank;

    int                 fill_estimate;
    int                 tx_gaps_on;
    int                 rx_stall_pct;
    int                 rx_hold = 0;
    int                 idle_cycles = 0;
    logic [VALUE_W-1:0] value_pool [8];

    always #5 aclk = ~aclk;

    max_frequency_stack_top #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status)
    );

    mfs_stack_checker #(
        .DEPTH(STACK_DEPTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .mismatches     (mismatch_total),
        .pending        (replies_pending),
        .pushes_done    (pushes_done),
        .pops_done      (pops_done),
        .refusals       (refusals),
        .peak_fill      (peak_fill),
        .peak_rank      (peak_rank)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    // A narrow pool makes repeated values, and so high counts and ties, common.
    function automatic logic [VALUE_W-1:0] next_value();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 65) return value_pool[$urandom_range(0, 3)];
        if (roll < 85) return value_pool[$urandom_range(4, 7)];
        return VALUE_W'($urandom());
    endfunction

    task automatic send_op(input logic kind, input logic [VALUE_W-1:0] value);
        int gap;

        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_PUSH) begin
            if (fill_estimate < STACK_DEPTH) fill_estimate++;
        end else if (fill_estimate > 0) begin
            fill_estimate--;
        end
    endtask

    // Holds the sender off until every reply has come back.
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_pending != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid === 1'b1 && m_ready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int  i;
        int  push_pct;
        logic kind;

        s_valid      <= 1'b0;
        s_kind       <= KIND_PUSH;
        s_value      <= '0;
        aresetn      <= 1'b0;
        fill_estimate = 0;
        tx_gaps_on    = 1;
        rx_stall_pct  = 30;
        value_pool[0] = '0;
        value_pool[1] = ALL_ONES;
        for (i = 2; i < 8; i++) value_pool[i] = VALUE_W'($urandom());

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pop, extreme values, counts above one, ties on the top count.
        send_op(KIND_POP, ALL_ONES);
        send_op(KIND_PUSH, '0);
        send_op(KIND_PUSH, ALL_ONES);
        send_op(KIND_PUSH, 30'h2AAA_AAAA);
        send_op(KIND_PUSH, 30'h1555_5555);
        send_op(KIND_PUSH, ALL_ONES);
        send_op(KIND_PUSH, '0);
        send_op(KIND_PUSH, '0);
        repeat (8) send_op(KIND_POP, VALUE_W'($urandom()));
        send_op(KIND_PUSH, 30'h0000_0011);
        send_op(KIND_PUSH, 30'h0000_0022);
        send_op(KIND_PUSH, 30'h0000_0022);
        send_op(KIND_PUSH, 30'h0000_0011);
        repeat (4) send_op(KIND_POP, '0);

        // Random walk over small fill levels, reaching empty now and then.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i / 90) % 3)
                0: begin
                    tx_gaps_on   = 1;
                    rx_stall_pct = 25;
                end
                1: begin
                    tx_gaps_on   = 0;
                    rx_stall_pct = 0;
                end
                default: begin
                    tx_gaps_on   = 1;
                    rx_stall_pct = 60;
                end
            endcase
            if (i == RANDOM_ITEMS / 2) drain_replies();
            if (fill_estimate == 0) push_pct = 80;
            else if (fill_estimate < 24) push_pct = 60;
            else if (fill_estimate < 48) push_pct = 45;
            else push_pct = 25;
            kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            send_op(kind, (kind == KIND_PUSH) ? next_value() : VALUE_W'($urandom()));
        end

        // A burst of one dominant value, then pops that dig beneath it.
        tx_gaps_on   = 0;
        rx_stall_pct = 10;
        repeat (12) begin
            send_op(KIND_PUSH, ($urandom_range(0, 7) != 0) ? value_pool[2] : next_value());
        end
        tx_gaps_on = 1;
        send_op(KIND_PUSH, ALL_ONES);
        send_op(KIND_PUSH, '0);
        repeat (5) send_op(KIND_POP, VALUE_W'($urandom()));
        send_op(KIND_PUSH, value_pool[2]);
        send_op(KIND_POP, '0);

        drain_replies();
        repeat (16) @(posedge aclk);

        $display("Covered %0d pushes and %0d pops, %0d refused on a full or empty stack.",
                 pushes_done, pops_done, refusals);
        $display("Stack reached %0d of %0d entries; highest count seen was %0d.",
                 peak_fill, STACK_DEPTH, peak_rank);
        if (mismatch_total == 0 && replies_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
